// ===== hw/rtl/lssfe_pkg.sv =====
`timescale 1ns / 1ps

package lssfe_pkg;

   // Strip geometry defaults
   localparam int unsigned LED_COUNT_DEFAULT   = 16;
   localparam int unsigned RESET_BYTES_DEFAULT = 64;

   // Frame output
   localparam int unsigned MAX_CHUNKS = 56;
   localparam int unsigned CHUNK_W    = 6;
   localparam logic [7:0]  SPI_ONE    = 8'hFC;
   localparam logic [7:0]  SPI_ZERO   = 8'hC0;

   // Breathing phase
   localparam int unsigned PHASE_COUNT = 126;
   localparam int unsigned PHASE_SLOTS = 128;
   localparam logic [6:0]  PHASE_LAST  = 7'd125;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W      = 2;
   localparam logic [1:0]  CSR_BREATH_RED   = 2'd0;
   localparam logic [1:0]  CSR_BREATH_GREEN = 2'd1;
   localparam logic [1:0]  CSR_BREATH_BLUE  = 2'd2;
   localparam logic [1:0]  CSR_BREATH_EN    = 2'd3;

   // Request codes on the input channel
   localparam logic [2:0] REQ_SET_ONE  = 3'd0;
   localparam logic [2:0] REQ_SET_ALL  = 3'd1;
   localparam logic [2:0] REQ_REFRESH  = 3'd2;
   localparam logic [2:0] REQ_TICK     = 3'd3;
   localparam logic [2:0] REQ_RESTART  = 3'd4;

   // Fixed-point constants in Q2.30
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [2:0] {
      OP_SET_ONE,
      OP_SET_ALL,
      OP_REFRESH,
      OP_TICK,
      OP_RESTART,
      OP_NOP
   } op_type;

   typedef struct packed {
      op_type      op;
      logic        bad_index;
      logic [7:0]  led_index;
      logic [23:0] color;      // {red, green, blue}
   } cmd_type;

   // (sin(k/20)+1)/2 in Q0.16, Taylor series in Q2.30 with truncating products
   function automatic logic [15:0] intensity_q16(input logic [6:0] k);
      logic [63:0] x;
      logic [63:0] r2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] v;
      logic        neg;
      x   = {57'd0, k} << 30;
      x   = x / 64'd20;
      neg = 1'b0;
      if (x >= PI_Q30) begin
         x   = x - PI_Q30;
         neg = 1'b1;
      end
      if (x > HALF_PI_Q30) begin
         x = PI_Q30 - x;
      end
      r2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n <= 10; n++) begin
         term = (term * r2) >> 30;
         term = term / 64'((2 * n) * (2 * n + 1));
         if ((n & 1) != 0) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > ONE_Q30) begin
         sum = ONE_Q30;
      end
      v = neg ? (ONE_Q30 - sum) : (ONE_Q30 + sum);
      v = (v + 64'd16384) >> 15;
      if (v > 64'd65535) begin
         v = 64'd65535;
      end
      return v[15:0];
   endfunction

   function automatic logic [PHASE_SLOTS*16-1:0] build_intensity_table();
      logic [PHASE_SLOTS*16-1:0] t;
      t = '0;
      for (int k = 0; k < PHASE_COUNT; k++) begin
         t[k*16 +: 16] = intensity_q16(7'(k));
      end
      return t;
   endfunction

   localparam logic [PHASE_SLOTS*16-1:0] INTENSITY_TABLE = build_intensity_table();

   function automatic logic [15:0] intensity_lookup(input logic [6:0] phase);
      return INTENSITY_TABLE[{phase, 4'b0000} +: 16];
   endfunction

endpackage

// ===== hw/rtl/lssfe_front.sv =====
`timescale 1ns / 1ps

module lssfe_front #(
   parameter int unsigned LED_COUNT = lssfe_pkg::LED_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [31:0]        req_tdata,   // led_index, red, green, blue
   input  logic [2:0]         req_tuser,   // req_type
   output lssfe_pkg::cmd_type cmd,
   output logic               cmd_valid,
   input  logic               cmd_ready
);

   lssfe_pkg::cmd_type cmd_in;
   lssfe_pkg::cmd_type cmd_ff;
   logic               valid_ff;
   logic               accept;

   always_comb begin
      cmd_in.led_index = req_tdata[7:0];
      cmd_in.color     = {req_tdata[15:8], req_tdata[23:16], req_tdata[31:24]};
      cmd_in.bad_index = 1'b0;
      case (req_tuser)
         lssfe_pkg::REQ_SET_ONE: begin
            cmd_in.op        = lssfe_pkg::OP_SET_ONE;
            cmd_in.bad_index = (req_tdata[7:0] >= 8'(LED_COUNT));
         end
         lssfe_pkg::REQ_SET_ALL: cmd_in.op = lssfe_pkg::OP_SET_ALL;
         lssfe_pkg::REQ_REFRESH: cmd_in.op = lssfe_pkg::OP_REFRESH;
         lssfe_pkg::REQ_TICK:    cmd_in.op = lssfe_pkg::OP_TICK;
         lssfe_pkg::REQ_RESTART: cmd_in.op = lssfe_pkg::OP_RESTART;
         default:                cmd_in.op = lssfe_pkg::OP_NOP;
      endcase
   end

   assign req_tready = !valid_ff || cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_ff;
   assign cmd_valid  = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (accept) begin
         valid_ff <= 1'b1;
      end else if (cmd_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/lssfe_queue.sv =====
`timescale 1ns / 1ps

module lssfe_queue (
   input  logic               clock,
   input  logic               reset,
   input  lssfe_pkg::cmd_type push_cmd,
   input  logic               push_valid,
   output logic               push_ready,
   output lssfe_pkg::cmd_type pop_cmd,
   output logic               pop_valid,
   input  logic               pop_ready
);

   lssfe_pkg::cmd_type entry_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_ready && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop_ready |-> count_ff != 2'd0)
      else $error("queue popped while empty");

endmodule

// ===== hw/rtl/lssfe_back.sv =====
`timescale 1ns / 1ps

module lssfe_back #(
   parameter int unsigned LED_COUNT   = lssfe_pkg::LED_COUNT_DEFAULT,
   parameter int unsigned RESET_BYTES = lssfe_pkg::RESET_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lssfe_pkg::cmd_type                cmd,
   input  logic                              cmd_valid,
   output logic                              cmd_pop,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lssfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_wdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [71:0]                       rsp_tdata,  // status, chunk
   output logic                              rsp_tuser,  // kind
   output logic                              rsp_tlast
);

   localparam int unsigned LED_W        = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
   localparam int unsigned DATA_CHUNKS  = 3 * LED_COUNT;
   localparam int unsigned RESET_CHUNKS = (RESET_BYTES + 7) / 8;
   localparam int unsigned ALL_CHUNKS   = DATA_CHUNKS + RESET_CHUNKS;
   localparam int unsigned FRAME_CHUNKS =
      (ALL_CHUNKS > lssfe_pkg::MAX_CHUNKS) ? lssfe_pkg::MAX_CHUNKS : ALL_CHUNKS;
   localparam logic [lssfe_pkg::CHUNK_W-1:0] LAST_CHUNK =
      lssfe_pkg::CHUNK_W'(FRAME_CHUNKS - 1);
   localparam logic [lssfe_pkg::CHUNK_W-1:0] DATA_END =
      lssfe_pkg::CHUNK_W'(DATA_CHUNKS);

   // Color slot within one LED, in wire order
   localparam logic [1:0] SLOT_GREEN = 2'd0;
   localparam logic [1:0] SLOT_RED   = 2'd1;
   localparam logic [1:0] SLOT_BLUE  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_LOOKUP,
      ST_SCALE,
      ST_APPLY,
      ST_FRAME
   } state_type;

   state_type                     state_ff;
   lssfe_pkg::cmd_type            cmd_ff;
   logic [6:0]                    phase_ff;
   logic [6:0]                    phase_in;
   logic [15:0]                   level_ff;
   logic [23:0]                   prod_r_ff;
   logic [23:0]                   prod_g_ff;
   logic [23:0]                   prod_b_ff;
   logic [lssfe_pkg::CHUNK_W-1:0] chunk_cnt_ff;
   logic [LED_W-1:0]              led_cnt_ff;
   logic [1:0]                    slot_ff;

   logic [7:0]  breath_red_ff;
   logic [7:0]  breath_green_ff;
   logic [7:0]  breath_blue_ff;
   logic        breath_en_ff;

   logic [23:0] store_ff [LED_COUNT];
   logic        store_we_one;
   logic        store_we_all;
   logic [23:0] store_wdata;

   logic        rsp_valid_ff;
   logic        rsp_kind_ff;
   logic        rsp_status_ff;
   logic [63:0] rsp_chunk_ff;
   logic        rsp_last_ff;

   logic        out_free;
   logic        rsp_load;
   logic        in_data;
   logic [23:0] led_color;
   logic [7:0]  slot_byte;
   logic [63:0] chunk_in;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid;
   assign csr_ready = 1'b1;
   assign phase_in  = (phase_ff >= lssfe_pkg::PHASE_LAST) ? 7'd0 : phase_ff + 7'd1;

   // Load the output register with a status or a frame chunk
   assign rsp_load = out_free &&
                     ((state_ff == ST_FRAME) ||
                      ((state_ff == ST_EXEC) && (cmd_ff.op != lssfe_pkg::OP_REFRESH) &&
                       !((cmd_ff.op == lssfe_pkg::OP_TICK) && breath_en_ff)));

   // Expand one color byte into eight SPI bytes, MSB first in the top byte
   assign in_data   = (chunk_cnt_ff < DATA_END);
   assign led_color = store_ff[led_cnt_ff];

   always_comb begin
      case (slot_ff)
         SLOT_GREEN: slot_byte = led_color[15:8];
         SLOT_RED:   slot_byte = led_color[23:16];
         default:    slot_byte = led_color[7:0];
      endcase
      chunk_in = '0;
      if (in_data) begin
         for (int i = 0; i < 8; i++) begin
            chunk_in[i*8 +: 8] = slot_byte[i] ? lssfe_pkg::SPI_ONE : lssfe_pkg::SPI_ZERO;
         end
      end
   end

   assign store_we_one = (state_ff == ST_EXEC) && out_free &&
                         (cmd_ff.op == lssfe_pkg::OP_SET_ONE) && !cmd_ff.bad_index;
   assign store_we_all = ((state_ff == ST_EXEC) && out_free &&
                          (cmd_ff.op == lssfe_pkg::OP_SET_ALL)) ||
                         (state_ff == ST_APPLY);
   assign store_wdata  = (state_ff == ST_APPLY) ?
                         {prod_r_ff[23:16], prod_g_ff[23:16], prod_b_ff[23:16]} :
                         cmd_ff.color;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            store_ff[i] <= '0;
         end
      end else if (store_we_all) begin
         for (int i = 0; i < LED_COUNT; i++) begin
            store_ff[i] <= store_wdata;
         end
      end else if (store_we_one) begin
         store_ff[cmd_ff.led_index[LED_W-1:0]] <= store_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breath_red_ff   <= 8'd50;
         breath_green_ff <= 8'd50;
         breath_blue_ff  <= 8'd50;
         breath_en_ff    <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            lssfe_pkg::CSR_BREATH_RED:   breath_red_ff   <= csr_wdata;
            lssfe_pkg::CSR_BREATH_GREEN: breath_green_ff <= csr_wdata;
            lssfe_pkg::CSR_BREATH_BLUE:  breath_blue_ff  <= csr_wdata;
            lssfe_pkg::CSR_BREATH_EN:    breath_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 7'd0;
         rsp_valid_ff <= 1'b0;
         chunk_cnt_ff <= '0;
         led_cnt_ff   <= '0;
         slot_ff      <= SLOT_GREEN;
      end else begin
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_tready);
         case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff   <= cmd;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd_ff.op == lssfe_pkg::OP_REFRESH) begin
                  chunk_cnt_ff <= '0;
                  led_cnt_ff   <= '0;
                  slot_ff      <= SLOT_GREEN;
                  state_ff     <= ST_FRAME;
               end else if ((cmd_ff.op == lssfe_pkg::OP_TICK) && breath_en_ff) begin
                  phase_ff <= phase_in;
                  state_ff <= ST_LOOKUP;
               end else if (out_free) begin
                  rsp_kind_ff   <= 1'b0;
                  rsp_status_ff <= cmd_ff.bad_index;
                  rsp_chunk_ff  <= '0;
                  rsp_last_ff   <= 1'b1;
                  if (cmd_ff.op == lssfe_pkg::OP_RESTART) begin
                     phase_ff <= 7'd0;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            ST_LOOKUP: begin
               level_ff <= lssfe_pkg::intensity_lookup(phase_ff);
               state_ff <= ST_SCALE;
            end
            ST_SCALE: begin
               prod_r_ff <= {16'd0, breath_red_ff} * {8'd0, level_ff};
               prod_g_ff <= {16'd0, breath_green_ff} * {8'd0, level_ff};
               prod_b_ff <= {16'd0, breath_blue_ff} * {8'd0, level_ff};
               state_ff  <= ST_APPLY;
            end
            ST_APPLY: begin
               chunk_cnt_ff <= '0;
               led_cnt_ff   <= '0;
               slot_ff      <= SLOT_GREEN;
               state_ff     <= ST_FRAME;
            end
            ST_FRAME: begin
               if (out_free) begin
                  rsp_kind_ff   <= 1'b1;
                  rsp_status_ff <= 1'b0;
                  rsp_chunk_ff  <= chunk_in;
                  rsp_last_ff   <= (chunk_cnt_ff == LAST_CHUNK);
                  chunk_cnt_ff  <= chunk_cnt_ff + 1'b1;
                  // hold the LED pointer once the reset bytes start
                  if (in_data) begin
                     if (slot_ff == SLOT_BLUE) begin
                        slot_ff <= SLOT_GREEN;
                        if (chunk_cnt_ff != DATA_END - 1'b1) begin
                           led_cnt_ff <= led_cnt_ff + 1'b1;
                        end
                     end else begin
                        slot_ff <= slot_ff + 2'd1;
                     end
                  end
                  if (chunk_cnt_ff == LAST_CHUNK) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_chunk_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= lssfe_pkg::PHASE_LAST)
      else $error("breathing phase out of range");

   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_kind_ff |-> rsp_last_ff)
      else $error("status transaction without last");

   a_chunk_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FRAME |-> chunk_cnt_ff <= LAST_CHUNK)
      else $error("frame chunk counter past end");

   a_no_write_in_frame: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FRAME |-> !(store_we_one || store_we_all))
      else $error("color store written during frame");

endmodule

// ===== hw/rtl/led_strip_spi_frame_encoder.sv =====
`timescale 1ns / 1ps

// LED strip SPI frame encoder.
// req channel: one transaction per request; req_tuser is the request code (set one LED,
// set all, refresh, breathing tick, restart phase), req_tdata carries index and color.
// rsp channel: a status transaction (rsp_tuser 0) or a run of 64-bit frame chunks
// (rsp_tuser 1); rsp_tlast marks the final transaction of each request.
// csr channel: write-only, always ready; index 0..3 selects breath red, green, blue, enable.
// A request passes an input register and a two-entry queue before the executor, which
// registers its status result in the output register. A refresh streams one chunk per
// cycle while rsp_tready is high, 3*LED_COUNT + RESET_BYTES/8 (rounded up) chunks, at
// most 56 (56 with defaults); an enabled tick first does the intensity lookup, the color
// scaling and the store update, then streams a frame. Item rate is set by the single
// executor: one request at a time, its results one per cycle while rsp_tready is high.
// The queue takes requests until full while the executor waits on a stalled receiver; the
// output register holds its transaction until taken. Reset clears the color store, the
// breathing phase and the queue, and loads the breathing color 50,50,50 with breathing off.
module led_strip_spi_frame_encoder #(
   parameter int unsigned LED_COUNT   = lssfe_pkg::LED_COUNT_DEFAULT,
   parameter int unsigned RESET_BYTES = lssfe_pkg::RESET_BYTES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [31:0]                       req_tdata,  // led_index, red, green, blue
   input  logic [2:0]                        req_tuser,  // req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [71:0]                       rsp_tdata,  // status, chunk, zero pad
   output logic                              rsp_tuser,  // kind
   output logic                              rsp_tlast,  // last
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [lssfe_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]                        csr_wdata
);

   lssfe_pkg::cmd_type front_cmd;
   logic               front_valid;
   logic               front_ready;
   lssfe_pkg::cmd_type queue_cmd;
   logic               queue_valid;
   logic               queue_pop;

   lssfe_front #(
      .LED_COUNT (LED_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (front_cmd),
      .cmd_valid  (front_valid),
      .cmd_ready  (front_ready)
   );

   lssfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_cmd   (front_cmd),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .pop_cmd    (queue_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_pop)
   );

   lssfe_back #(
      .LED_COUNT   (LED_COUNT),
      .RESET_BYTES (RESET_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (queue_cmd),
      .cmd_valid  (queue_valid),
      .cmd_pop    (queue_pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== bench/led_strip_spi_frame_encoder_tb.sv =====
`timescale 1ns / 1ps

module led_strip_spi_frame_encoder_tb;

   localparam int unsigned STRIP_LEDS    = 16;
   localparam int unsigned TRAILER_BYTES = 64;
   localparam int unsigned FRAME_BYTES   = STRIP_LEDS * 24 + TRAILER_BYTES;
   localparam int unsigned CHUNK_CAP     = 56;
   localparam logic [7:0]  BYTE_FOR_ONE  = 8'hFC;
   localparam logic [7:0]  BYTE_FOR_ZERO = 8'hC0;
   localparam logic [6:0]  PHASE_TOP     = 7'd125;
   localparam logic [2:0]  REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0]  REQ_SPARE_MID = 3'd6;
   localparam logic [2:0]  REQ_SPARE_HI  = 3'd7;
   localparam logic [63:0] Q30_PI        = 64'd3373259426;
   localparam logic [63:0] Q30_HALF_PI   = 64'd1686629713;
   localparam logic [63:0] Q30_ONE       = 64'd1073741824;
   localparam int          LONG_HOLD     = 600;
   localparam int          SETTLE        = 12;
   localparam int          TAIL_CYCLES   = 24;
   localparam int          QUIET_LIMIT   = 5000;
   localparam int          DIRECTED_ROWS = 25;

   typedef struct packed {
      logic        kind;
      logic        status;
      logic [63:0] chunk;
      logic        last;
   } strip_word_type;

   typedef struct {
      bit         reprogram;    // drain, then load r/g/b/en into the breathing registers
      logic [2:0] req;
      logic [7:0] idx;
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
      bit         en;
      bit         typed;        // status result typed in the row
      bit         typed_status;
   } vector_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;     // led_index, red, green, blue
   logic [2:0]  req_tuser = lssfe_pkg::REQ_SET_ONE; // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;          // status, chunk, zero pad
   logic        rsp_tuser;          // kind
   logic        rsp_tlast;          // last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [lssfe_pkg::CSR_INDEX_W-1:0] csr_index = lssfe_pkg::CSR_BREATH_RED;
   logic [7:0]  csr_wdata = '0;

   // Shadow of the strip state
   logic [23:0] led_rgb [STRIP_LEDS];
   logic [6:0]  shadow_phase;
   logic [7:0]  cfg_red, cfg_green, cfg_blue;
   logic        cfg_enable;

   strip_word_type pending_words[$];
   vector_type     directed [DIRECTED_ROWS];

   int  mismatches = 0;
   int  items_sent = 0;
   int  ticks_live = 0;
   int  phase_wraps = 0;
   int  chunks_seen = 0;
   int  status_seen = 0;
   int  quiet_cycles = 0;
   int  src_calm = 0;
   int  sink_calm = 0;
   bit  long_hold_req = 1'b0;

   led_strip_spi_frame_encoder #(
      .LED_COUNT  (STRIP_LEDS),
      .RESET_BYTES(TRAILER_BYTES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly random waits, with runs of back-to-back transactions now and then
   function automatic int draw_wait(ref int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 14);
   endfunction

   // (sin(k/20)+1)/2 in Q0.16 via a truncating Q2.30 Taylor series
   function automatic logic [15:0] breath_level(input logic [6:0] k);
      logic [63:0] ang;
      logic [63:0] sq;
      logic [63:0] t;
      logic [63:0] acc;
      logic [63:0] v;
      logic [63:0] div;
      bit          lower_half;
      ang = {57'd0, k};
      ang = (ang << 30) / 64'd20;
      lower_half = 1'b0;
      if (ang >= Q30_PI) begin
         ang = ang - Q30_PI;
         lower_half = 1'b1;
      end
      if (ang > Q30_HALF_PI) ang = Q30_PI - ang;
      sq  = (ang * ang) >> 30;
      t   = ang;
      acc = ang;
      for (int n = 1; n <= 10; n++) begin
         t   = (t * sq) >> 30;
         div = 64'((2 * n) * (2 * n + 1));
         t   = t / div;
         if (n % 2 == 1) acc = acc - t;
         else acc = acc + t;
      end
      if (acc > Q30_ONE) acc = Q30_ONE;
      v = lower_half ? (Q30_ONE - acc) : (Q30_ONE + acc);
      v = (v + 64'd16384) >> 15;
      if (v > 64'd65535) v = 64'd65535;
      return v[15:0];
   endfunction

   task automatic owe_status(input logic st);
      pending_words.push_back(strip_word_type'{1'b0, st, 64'd0, 1'b1});
   endtask

   task automatic owe_frame();
      logic [63:0] word;
      logic [23:0] grb;
      logic [7:0]  by;
      int          pos;
      int          chunks;
      chunks = (FRAME_BYTES + 7) / 8;
      if (chunks > CHUNK_CAP) chunks = CHUNK_CAP;
      for (int k = 0; k < chunks; k++) begin
         word = '0;
         for (int j = 0; j < 8; j++) begin
            pos = k * 8 + j;
            if (pos < STRIP_LEDS * 24) begin
               grb = {led_rgb[pos / 24][15:8], led_rgb[pos / 24][23:16],
                      led_rgb[pos / 24][7:0]};
               by  = grb[23 - pos % 24] ? BYTE_FOR_ONE : BYTE_FOR_ZERO;
            end else begin
               by = 8'h00;
            end
            word = {word[55:0], by};
         end
         pending_words.push_back(strip_word_type'{1'b1, 1'b0, word, (k == chunks - 1)});
      end
   endtask

   task automatic fill_strip(input logic [23:0] rgb);
      for (int i = 0; i < STRIP_LEDS; i++) led_rgb[i] = rgb;
   endtask

   task automatic encode_request(input logic [2:0] code, input logic [7:0] idx,
                                 input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b);
      logic [15:0] q;
      logic [31:0] sr, sg, sb;
      case (code)
         lssfe_pkg::REQ_SET_ONE: begin
            if (idx >= STRIP_LEDS) begin
               owe_status(1'b1);
            end else begin
               led_rgb[idx] = {r, g, b};
               owe_status(1'b0);
            end
         end
         lssfe_pkg::REQ_SET_ALL: begin
            fill_strip({r, g, b});
            owe_status(1'b0);
         end
         lssfe_pkg::REQ_REFRESH: owe_frame();
         lssfe_pkg::REQ_TICK: begin
            if (!cfg_enable) begin
               owe_status(1'b0);
            end else begin
               ticks_live++;
               if (shadow_phase >= PHASE_TOP) begin
                  shadow_phase = '0;
                  phase_wraps++;
               end else begin
                  shadow_phase = shadow_phase + 7'd1;
               end
               q  = breath_level(shadow_phase);
               sr = (32'(cfg_red) * 32'(q)) >> 16;
               sg = (32'(cfg_green) * 32'(q)) >> 16;
               sb = (32'(cfg_blue) * 32'(q)) >> 16;
               fill_strip({sr[7:0], sg[7:0], sb[7:0]});
               owe_frame();
            end
         end
         lssfe_pkg::REQ_RESTART: begin
            shadow_phase = '0;
            owe_status(1'b0);
         end
         default: owe_status(1'b0);
      endcase
   endtask

   task automatic offer_request(input logic [2:0] code, input logic [7:0] idx,
                                input logic [7:0] r, input logic [7:0] g,
                                input logic [7:0] b, input bit typed,
                                input bit typed_status);
      int gap;
      gap = draw_wait(src_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= {b, g, r, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encode_request(code, idx, r, g, b);
      if (typed) begin
         // replace the prediction with the status typed in the row
         void'(pending_words.pop_back());
         owe_status(typed_status);
      end
      items_sent++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_breath(input logic [7:0] r, input logic [7:0] g,
                                 input logic [7:0] b, input bit en);
      logic [lssfe_pkg::CSR_INDEX_W-1:0] which [4];
      logic [7:0]                        val [4];
      wait_idle();
      which = '{lssfe_pkg::CSR_BREATH_RED, lssfe_pkg::CSR_BREATH_GREEN,
                lssfe_pkg::CSR_BREATH_BLUE, lssfe_pkg::CSR_BREATH_EN};
      // only bit 0 of the enable write matters; scramble the rest
      val = '{r, g, b, {7'($urandom), en}};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= which[i];
         csr_wdata <= val[i];
         @(posedge clock);
         while (!csr_ready) @(posedge clock);
      end
      csr_valid  <= 1'b0;
      cfg_red    = r;
      cfg_green  = g;
      cfg_blue   = b;
      cfg_enable = en;
   endtask

   function automatic logic [7:0] pick_level();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic random_request(input bit sweep);
      int          pick;
      logic [2:0]  code;
      logic [7:0]  idx;
      pick = $urandom_range(0, 99);
      idx  = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, STRIP_LEDS - 1));
      if (sweep || (pick >= 50 && pick < 78)) code = lssfe_pkg::REQ_TICK;
      else if (pick < 26) code = lssfe_pkg::REQ_SET_ONE;
      else if (pick < 38) code = lssfe_pkg::REQ_SET_ALL;
      else if (pick < 50) code = lssfe_pkg::REQ_REFRESH;
      else if (pick < 92) code = lssfe_pkg::REQ_RESTART;
      else code = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      offer_request(code, idx, pick_level(), pick_level(), pick_level(), 1'b0, 1'b0);
   endtask

   task automatic run_random(input int count, input bit sweep);
      for (int i = 0; i < count; i++) random_request(sweep);
   endtask

   // Result checker
   always @(posedge clock) begin
      strip_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser) chunks_seen++;
         else status_seen++;
         if (pending_words.size() == 0) begin
            $error("unexpected result: kind %0d chunk %h", rsp_tuser, rsp_tdata[64:1]);
            mismatches++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tuser !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[0] !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[64:1] !== want.chunk) begin
               $error("chunk: expected %h, got %h", want.chunk, rsp_tdata[64:1]);
               mismatches++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: cycles without any transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("timeout after %0d quiet cycles", quiet_cycles);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver
   initial begin : sink
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = draw_wait(sink_calm);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            w = LONG_HOLD;
         end
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      directed = '{
         '{0, lssfe_pkg::REQ_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},  // cleared strip
         '{0, lssfe_pkg::REQ_SET_ONE, 8'd0,  8'hFF, 8'h00, 8'h00, 0, 1, 0},
         '{0, lssfe_pkg::REQ_SET_ONE, 8'd15, 8'h00, 8'hFF, 8'h00, 0, 1, 0},
         // first index out of range
         '{0, lssfe_pkg::REQ_SET_ONE, 8'd16, 8'h12, 8'h34, 8'h56, 0, 1, 1},
         '{0, lssfe_pkg::REQ_SET_ONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1, 1},
         '{0, lssfe_pkg::REQ_SET_ONE, 8'd7,  8'hAA, 8'h55, 8'h0F, 0, 0, 0},
         '{0, lssfe_pkg::REQ_REFRESH, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0},  // breathing off
         '{0, REQ_SPARE_LO,           8'h5A, 8'hA5, 8'h5A, 8'hA5, 0, 1, 0},
         '{0, REQ_SPARE_HI,           8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 1, 0},
         '{0, lssfe_pkg::REQ_RESTART, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0},
         '{0, lssfe_pkg::REQ_SET_ALL, 8'h00, 8'hFF, 8'hFF, 8'hFF, 0, 1, 0},
         '{0, lssfe_pkg::REQ_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{1, lssfe_pkg::REQ_SET_ONE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 1, 0, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{0, lssfe_pkg::REQ_RESTART, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{1, lssfe_pkg::REQ_SET_ONE, 8'h00, 8'h00, 8'h00, 8'h00, 1, 0, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{0, lssfe_pkg::REQ_SET_ALL, 8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0},
         '{0, lssfe_pkg::REQ_REFRESH, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0, 0},
         '{1, lssfe_pkg::REQ_SET_ONE, 8'h00, 8'd50, 8'd50, 8'd50, 0, 0, 0},
         '{0, REQ_SPARE_MID,          8'h0F, 8'hF0, 8'h0F, 8'hF0, 0, 1, 0},
         '{0, lssfe_pkg::REQ_TICK,    8'h00, 8'h00, 8'h00, 8'h00, 0, 1, 0}
      };
      fill_strip(24'd0);
      shadow_phase = '0;
      cfg_red      = 8'd50;
      cfg_green    = 8'd50;
      cfg_blue     = 8'd50;
      cfg_enable   = 1'b0;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (directed[i].reprogram) begin
            program_breath(directed[i].r, directed[i].g, directed[i].b, directed[i].en);
         end else begin
            offer_request(directed[i].req, directed[i].idx, directed[i].r, directed[i].g,
                          directed[i].b, directed[i].typed, directed[i].typed_status);
         end
      end

      // reset settings, with a long receiver stall while requests keep coming
      wait_idle();
      long_hold_req = 1'b1;
      run_random(100, 1'b0);
      program_breath(8'hFF, 8'hFF, 8'hFF, 1'b1);
      run_random(100, 1'b0);
      program_breath(8'h00, 8'h00, 8'h00, 1'b1);
      run_random(60, 1'b0);
      // unbroken ticks so the phase wraps
      program_breath(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
      run_random(130, 1'b1);
      program_breath(8'($urandom), 8'($urandom), 8'($urandom), 1'b0);
      run_random(80, 1'b0);
      program_breath(8'hFF, 8'h00, 8'h80, 1'b1);
      run_random(60, 1'b0);

      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d requests: %0d live breathing ticks, %0d phase wraps.",
               items_sent, ticks_live, phase_wraps);
      $display("Checked %0d frame chunks and %0d status transactions.",
               chunks_seen, status_seen);
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/lssfe_pkg.sv
hw/rtl/lssfe_front.sv
hw/rtl/lssfe_queue.sv
hw/rtl/lssfe_back.sv
hw/rtl/led_strip_spi_frame_encoder.sv
bench/led_strip_spi_frame_encoder_tb.sv
